/* sv/lifn_pkg.sv */
// Package for the LIF neuron soft-reset step unit.
// Holds sizes, register map, FP32 constants and the staged FP32 multiply/add helpers.
// No dependencies.
package lifn_pkg;

    // Neuron store geometry
    localparam int NEURONS = 1024;
    localparam int IDX_W   = 10;

    // APB register map (word index taken from paddr[2])
    localparam int  PADDR_W   = 3;
    localparam logic REG_DECAY  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // FP32 constants
    localparam logic [31:0] FP_ZERO      = 32'h0000_0000;
    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] FP_SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] FP_DEF_NAN   = 32'hFFC0_0000;

    localparam logic [31:0] DECAY_RESET  = FP_ZERO;
    localparam logic [31:0] THRESH_RESET = FP_ONE;

    // Store clearing sequencer
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } lifn_state_t;

    // Multiplier stage 1 result: raw product and exponent
    typedef struct packed {
        logic               special;
        logic [31:0]        sval;
        logic               sign;
        logic signed [10:0] eraw;
        logic [47:0]        prod;
    } mul_a_t;

    // Multiplier stage 2 result: normalizing shift decided
    typedef struct packed {
        logic        special;
        logic [31:0] sval;
        logic        sign;
        logic        left;
        logic [5:0]  amt;
        logic [9:0]  e;
        logic [47:0] prod;
    } mul_b_t;

    // Adder stage 1 result: operands swapped and aligned
    typedef struct packed {
        logic        special;
        logic [31:0] sval;
        logic        same;
        logic        sign;
        logic [7:0]  e;
        logic [26:0] big;
        logic [26:0] small_m;
    } add_a_t;

    // Adder stage 2 result: sum and leading zero count
    typedef struct packed {
        logic        special;
        logic [31:0] sval;
        logic        zero;
        logic        zsign;
        logic        sign;
        logic [8:0]  e;
        logic [26:0] m;
        logic [4:0]  lz;
    } add_b_t;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // IEEE a >= b; unordered gives 0, zeros compare equal
    function automatic logic fp_ge(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | FP_SIGN_BIT);
        kb = b[31] ? ~b : (b | FP_SIGN_BIT);
        if (fp_is_nan(a) || fp_is_nan(b))
            return 1'b0;
        if (fp_is_zero(a) && fp_is_zero(b))
            return 1'b1;
        return ka >= kb;
    endfunction

    // Subtrahend of the soft reset: spike*threshold, 1.0 or 0.0 times threshold
    function automatic logic [31:0] reset_term(input logic spk, input logic [31:0] thr);
        if (spk)
            return thr;
        if (fp_is_nan(thr))
            return thr | FP_QUIET_BIT;
        if (fp_is_inf(thr))
            return FP_DEF_NAN;
        return {thr[31], 31'd0};
    endfunction

    // Multiply, step 1: specials, mantissa product, exponent sum
    function automatic mul_a_t mul_unpack(input logic [31:0] a, input logic [31:0] b);
        mul_a_t      r;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        r.sign    = a[31] ^ b[31];
        r.eraw    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
        r.prod    = ma * mb;
        r.special = 1'b1;
        r.sval    = FP_ZERO;
        priority if (fp_is_nan(a))
            r.sval = a | FP_QUIET_BIT;
        else if (fp_is_nan(b))
            r.sval = b | FP_QUIET_BIT;
        else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b)))
            r.sval = FP_DEF_NAN;
        else if (fp_is_inf(a) || fp_is_inf(b))
            r.sval = {r.sign, 8'hFF, 23'd0};
        else if (fp_is_zero(a) || fp_is_zero(b))
            r.sval = {r.sign, 31'd0};
        else
            r.special = 1'b0;
        return r;
    endfunction

    // Multiply, step 2: leading zeros and shift direction/amount
    function automatic mul_b_t mul_norm(input mul_a_t x);
        mul_b_t             r;
        logic [5:0]         lz;
        logic signed [11:0] el;
        logic signed [11:0] rs;
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
            if (x.prod[i])
                lz = 6'(47 - i);
        el = 12'(x.eraw) - $signed({6'b000000, lz});
        rs = 12'sd1 - 12'(x.eraw);
        r.special = x.special;
        r.sval    = x.sval;
        r.sign    = x.sign;
        r.prod    = x.prod;
        priority if (el >= 12'sd1)
        begin
            r.left = 1'b1;
            r.amt  = lz;
            r.e    = el[9:0];
        end
        else if (x.eraw >= 11'sd1)
        begin
            r.left = 1'b1;
            r.amt  = 6'(x.eraw - 11'sd1);
            r.e    = 10'd1;
        end
        else
        begin
            r.left = 1'b0;
            r.amt  = (rs > 12'sd50) ? 6'd50 : rs[5:0];
            r.e    = 10'd1;
        end
        return r;
    endfunction

    // Multiply, step 3: shift, round to nearest even, pack
    function automatic logic [31:0] mul_round(input mul_b_t x);
        logic [47:0] sh;
        logic        sticky;
        logic        rnd;
        logic [24:0] m25;
        logic [23:0] m24;
        logic [9:0]  e;
        if (x.left)
        begin
            sh     = x.prod << x.amt;
            sticky = 1'b0;
        end
        else
        begin
            sh     = x.prod >> x.amt;
            sticky = |(x.prod & ((48'd1 << x.amt) - 48'd1));
        end
        rnd = sh[23] & ((|sh[22:0]) | sticky | sh[24]);
        m25 = {1'b0, sh[47:24]} + {24'd0, rnd};
        e   = x.e;
        if (m25[24])
        begin
            e   = e + 10'd1;
            m24 = m25[24:1];
        end
        else
            m24 = m25[23:0];
        if (x.special)
            return x.sval;
        if (e >= 10'd255)
            return {x.sign, 8'hFF, 23'd0};
        return {x.sign, m24[23] ? e[7:0] : 8'd0, m24[22:0]};
    endfunction

    // Add, step 1: specials, swap by magnitude, align the smaller operand.
    // bo is the operand as written, be is it with the effective sign.
    function automatic add_a_t add_align(input logic [31:0] a, input logic [31:0] be,
                                         input logic [31:0] bo);
        add_a_t      r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [26:0] mb;
        logic [26:0] ms;
        if (be[30:0] > a[30:0])
        begin
            big = be;
            sml = a;
        end
        else
        begin
            big = a;
            sml = be;
        end
        r.e  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb   = {big[30:23] != 8'd0, big[22:0], 3'b000};
        ms   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        d    = r.e - es;
        r.big  = mb;
        r.same = (big[31] == sml[31]);
        r.sign = big[31];
        if (d >= 8'd27)
            r.small_m = {26'd0, |ms};
        else
            r.small_m = (ms >> d) | {26'd0, |(ms & ((27'd1 << d) - 27'd1))};
        r.special = 1'b1;
        r.sval    = FP_ZERO;
        priority if (fp_is_nan(a))
            r.sval = a | FP_QUIET_BIT;
        else if (fp_is_nan(bo))
            r.sval = bo | FP_QUIET_BIT;
        else if (fp_is_inf(a) && fp_is_inf(be) && (a[31] != be[31]))
            r.sval = FP_DEF_NAN;
        else if (fp_is_inf(a))
            r.sval = a;
        else if (fp_is_inf(be))
            r.sval = be;
        else
            r.special = 1'b0;
        return r;
    endfunction

    // Add, step 2: add or subtract mantissas, fold a carry, count leading zeros
    function automatic add_b_t add_sum(input add_a_t x);
        add_b_t      r;
        logic [27:0] s;
        s = x.same ? ({1'b0, x.big} + {1'b0, x.small_m})
                   : ({1'b0, x.big} - {1'b0, x.small_m});
        r.special = x.special;
        r.sval    = x.sval;
        r.zero    = (s == 28'd0);
        r.zsign   = x.same ? x.sign : 1'b0;
        r.sign    = x.sign;
        if (s[27])
        begin
            r.m = {s[27:2], s[1] | s[0]};
            r.e = {1'b0, x.e} + 9'd1;
        end
        else
        begin
            r.m = s[26:0];
            r.e = {1'b0, x.e};
        end
        r.lz = 5'd27;
        for (int i = 0; i < 27; i++)
            if (r.m[i])
                r.lz = 5'(26 - i);
        return r;
    endfunction

    // Add, step 3: normalize (bounded by the minimum exponent), round, pack
    function automatic logic [31:0] add_round(input add_b_t x);
        logic [8:0]  lim;
        logic [4:0]  sh;
        logic [26:0] nm;
        logic [8:0]  ne;
        logic        rnd;
        logic [24:0] m25;
        logic [23:0] m24;
        lim = x.e - 9'd1;
        sh  = ({4'd0, x.lz} <= lim) ? x.lz : lim[4:0];
        nm  = x.m << sh;
        ne  = x.e - {4'd0, sh};
        rnd = nm[2] & (nm[1] | nm[0] | nm[3]);
        m25 = {1'b0, nm[26:3]} + {24'd0, rnd};
        if (m25[24])
        begin
            ne  = ne + 9'd1;
            m24 = m25[24:1];
        end
        else
            m24 = m25[23:0];
        if (x.special)
            return x.sval;
        if (x.zero)
            return {x.zsign, 31'd0};
        if (ne >= 9'd255)
            return {x.sign, 8'hFF, 23'd0};
        return {x.sign, m24[23] ? ne[7:0] : 8'd0, m24[22:0]};
    endfunction

endpackage

/* sv/lif_neuron_soft_reset_step_unit.sv */
// An accepted beat passes through the stage registers to its result beat in the output stage; one beat
// per cycle sustained while result_stall is low and no hazard holds. An item whose neuron is still in
// flight (not a first step) waits until that write lands, which sets the rate only in that case.
// Reset: async, active low; registers return to decay 0.0 and threshold 1.0, then a clearing
// pass zeroes the 1024-word membrane store word by word while item_stall is held high.
// Depends on lifn_pkg (FP32 stage functions, register map, constants).
module lif_neuron_soft_reset_step_unit
    import lifn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // item channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [IDX_W-1:0]     neuron_index,
    input  logic [31:0]          current_bits,
    input  logic                 first_step,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [31:0]          charged_bits,
    output logic                 spike
);

    localparam int LAST = 11;   // output stage
    localparam int WB   = 10;   // stage that writes the store

    // configuration
    logic [31:0] decay_reg;
    logic [31:0] thresh_reg;
    logic        cfg_wr;

    // clearing sequencer
    lifn_state_t      state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clearing;

    // pipeline control
    logic [LAST:1] v_reg, v_next;
    logic [LAST:1] can, mv, ld;
    logic          accept;
    logic          hazard;

    // membrane store
    logic [31:0] mem [NEURONS];
    logic [31:0] mem_rd_reg;
    logic [31:0] wb_data;

    // payload stages
    logic [IDX_W-1:0] idx_reg [1:WB];
    logic             s1_first_reg;
    logic [31:0]      s1_cur_reg, s2_cur_reg, s3_cur_reg, s4_cur_reg;
    mul_a_t           s2_mul_reg;
    mul_b_t           s3_mul_reg;
    logic [31:0]      s4_prod_reg;
    add_a_t           s5_add_reg;
    add_b_t           s6_add_reg;
    logic [31:0]      s7_charged_reg, s8_charged_reg, s9_charged_reg, s10_charged_reg;
    logic [31:0]      s11_charged_reg;
    logic             s8_spike_reg, s9_spike_reg, s10_spike_reg, s11_spike_reg;
    logic [31:0]      s8_sub_reg;
    add_a_t           s9_add_reg;
    add_b_t           s10_add_reg;
    logic             s7_spike;
    logic [31:0]      s1_mem;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_THRESH) ? thresh_reg : decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DECAY:  decay_reg  <= pwdata;
                REG_THRESH: thresh_reg <= pwdata;
                default:    decay_reg  <= decay_reg;
            endcase
        end
    end

    // clearing sequencer: next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NEURONS - 1))
                    state_next = ST_RUN;
            end
            ST_RUN:  state_next = ST_RUN;
            default: state_next = ST_CLEAR;
        endcase
    end

    // clearing sequencer: outputs
    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // hold a reader whose neuron has an older update still in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= WB; k++)
            if (v_reg[k] && (idx_reg[k] == neuron_index))
                hazard = 1'b1;
        hazard = hazard && !first_step;
    end

    // stage advance: a stage takes a beat when it is empty or its beat moves on
    always_comb
    begin
        can[LAST] = !v_reg[LAST] || !result_stall;
        mv[LAST]  = v_reg[LAST] && !result_stall;
        for (int k = LAST - 1; k >= 1; k--)
        begin
            can[k] = !v_reg[k] || can[k + 1];
            mv[k]  = v_reg[k] && can[k + 1];
        end
        item_stall = !can[1] || clearing || hazard;
        accept     = item_valid && !item_stall;
        ld[1]      = accept;
        for (int k = 2; k <= LAST; k++)
            ld[k] = mv[k - 1];
        for (int k = 1; k <= LAST; k++)
            v_next[k] = ld[k] || (v_reg[k] && !mv[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // membrane store: clear pass, write-back, registered read on accept
    assign wb_data = add_round(s10_add_reg);

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_cnt_reg] <= FP_ZERO;
        else if (mv[WB])
            mem[idx_reg[WB]] <= wb_data;
        if (accept)
            mem_rd_reg <= mem[neuron_index];
    end

    assign s1_mem   = s1_first_reg ? FP_ZERO : mem_rd_reg;
    assign s7_spike = fp_ge(s7_charged_reg, thresh_reg);

    // datapath: multiply in stages 2-4, charge add in 5-7, spike and subtrahend in 8, soft reset subtract in 9-10
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            idx_reg[1]   <= neuron_index;
            s1_first_reg <= first_step;
            s1_cur_reg   <= current_bits;
        end
        for (int k = 2; k <= WB; k++)
            if (ld[k])
                idx_reg[k] <= idx_reg[k - 1];
        if (ld[2])
        begin
            s2_cur_reg <= s1_cur_reg;
            s2_mul_reg <= mul_unpack(s1_mem, decay_reg);
        end
        if (ld[3])
        begin
            s3_cur_reg <= s2_cur_reg;
            s3_mul_reg <= mul_norm(s2_mul_reg);
        end
        if (ld[4])
        begin
            s4_cur_reg  <= s3_cur_reg;
            s4_prod_reg <= mul_round(s3_mul_reg);
        end
        if (ld[5])
            s5_add_reg <= add_align(s4_prod_reg, s4_cur_reg, s4_cur_reg);
        if (ld[6])
            s6_add_reg <= add_sum(s5_add_reg);
        if (ld[7])
            s7_charged_reg <= add_round(s6_add_reg);
        if (ld[8])
        begin
            s8_charged_reg <= s7_charged_reg;
            s8_spike_reg   <= s7_spike;
            s8_sub_reg     <= reset_term(s7_spike, thresh_reg);
        end
        if (ld[9])
        begin
            s9_charged_reg <= s8_charged_reg;
            s9_spike_reg   <= s8_spike_reg;
            s9_add_reg     <= add_align(s8_charged_reg, s8_sub_reg ^ FP_SIGN_BIT, s8_sub_reg);
        end
        if (ld[10])
        begin
            s10_charged_reg <= s9_charged_reg;
            s10_spike_reg   <= s9_spike_reg;
            s10_add_reg     <= add_sum(s9_add_reg);
        end
        if (ld[11])
        begin
            s11_charged_reg <= s10_charged_reg;
            s11_spike_reg   <= s10_spike_reg;
        end
    end

    // result beat
    assign result_valid = v_reg[LAST];
    assign charged_bits = s11_charged_reg;
    assign spike        = s11_spike_reg;

    // no beat enters while the store is being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept)
        else $error("beat accepted during clearing pass");

    // pipeline stays empty through the clearing pass
    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (v_reg == '0))
        else $error("pipeline busy during clearing pass");

    // a reader never overlaps the write-back of the same neuron
    a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !first_step && v_reg[WB]) |-> (idx_reg[WB] != neuron_index))
        else $error("read of a neuron with a pending write-back");

    // every accepted beat shows up in stage one next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v_reg[1])
        else $error("accepted beat lost at pipeline entry");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for lif_neuron_soft_reset_step_unit.
// Holds its own bit-exact FP32 neuron predictor, an item driver, a result monitor
// and the APB register writes. Depends on lifn_pkg for sizes, register codes and FP32 constants.
module tb_top
    import lifn_pkg::*;
();

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [31:0]      cur;
        logic             first;
    } neuron_item_t;

    typedef struct {
        logic [31:0] charged;
        logic        spk;
    } neuron_out_t;

    // unpacked FP32 value: magnitude = m * 2^e
    typedef struct {
        logic        s;
        logic [63:0] m;
        int          e;
    } fp_val_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 item_valid;
    logic                 item_stall;
    logic [IDX_W-1:0]     neuron_index;
    logic [31:0]          current_bits;
    logic                 first_step;
    logic                 result_valid;
    logic                 result_stall;
    logic [31:0]          charged_bits;
    logic                 spike;

    lif_neuron_soft_reset_step_unit uut (.*);

    // predictor copies of registers and membrane store
    logic [31:0]  decay_copy;
    logic [31:0]  thresh_copy;
    logic [31:0]  membrane_copy [NEURONS];

    neuron_item_t pending_items [$];
    neuron_out_t  expected_outs [$];
    int           mismatches;
    int           items_sent;
    int           outs_seen;
    int           spikes_seen;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ---------------- FP32 arithmetic, round to nearest even ----------------

    function automatic fp_val_t fp_unpack(input logic [31:0] x);
        fp_val_t v;
        v.s = x[31];
        if (x[30:23] == 8'd0)
        begin
            v.m = {41'd0, x[22:0]};
            v.e = -149;
        end
        else
        begin
            v.m = {40'd0, 1'b1, x[22:0]};
            v.e = int'(x[30:23]) - 150;
        end
        return v;
    endfunction

    function automatic logic [31:0] fp_round_pack(input logic s, input logic [63:0] m,
                                                  input int e);
        int           p;
        int           sh;
        int           lsb;
        logic [127:0] w;
        logic [127:0] r;
        logic [127:0] rem;
        logic [127:0] half;
        if (m == 64'd0)
            return {s, 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++)
            if (m[i])
                p = i;
        sh = p - 23;
        if (-149 - e > sh)
            sh = -149 - e;
        w = {64'd0, m};
        if (sh <= 0)
            r = w << (-sh);
        else if (sh >= 66)
            r = 128'd0;
        else
        begin
            r    = w >> sh;
            rem  = w & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && r[0]))
                r = r + 128'd1;
        end
        lsb = e + sh;
        if (r[24])
        begin
            r   = r >> 1;
            lsb = lsb + 1;
        end
        if (!r[23])
            return {s, 8'd0, r[22:0]};
        if (lsb + 150 >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, 8'(lsb + 150), r[22:0]};
    endfunction

    function automatic logic is_nan32(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf32(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        fp_val_t ua;
        fp_val_t ub;
        logic    s;
        s = a[31] ^ b[31];
        if (is_nan32(a))
            return a | FP_QUIET_BIT;
        if (is_nan32(b))
            return b | FP_QUIET_BIT;
        if ((is_inf32(a) && b[30:0] == 31'd0) || (is_inf32(b) && a[30:0] == 31'd0))
            return FP_DEF_NAN;
        if (is_inf32(a) || is_inf32(b))
            return {s, 8'hFF, 23'd0};
        ua = fp_unpack(a);
        ub = fp_unpack(b);
        return fp_round_pack(s, ua.m * ub.m, ua.e + ub.e);
    endfunction

    // a + b, or a - b when sub is set; NaN payload comes from b as written
    function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b,
                                             input logic sub);
        logic [31:0] be;
        fp_val_t     ua;
        fp_val_t     ub;
        logic [63:0] sum;
        logic        s;
        int          d;
        be = sub ? (b ^ FP_SIGN_BIT) : b;
        if (is_nan32(a))
            return a | FP_QUIET_BIT;
        if (is_nan32(b))
            return b | FP_QUIET_BIT;
        if (is_inf32(a) && is_inf32(be) && a[31] != be[31])
            return FP_DEF_NAN;
        if (is_inf32(a))
            return a;
        if (is_inf32(be))
            return be;
        ua = fp_unpack(a);
        ub = fp_unpack(be);
        // far-off small operand only matters as a sticky bit
        if (ua.e - ub.e > 30)
        begin
            ub.m = (ub.m != 64'd0) ? 64'd1 : 64'd0;
            ub.e = ua.e - 30;
        end
        else if (ub.e - ua.e > 30)
        begin
            ua.m = (ua.m != 64'd0) ? 64'd1 : 64'd0;
            ua.e = ub.e - 30;
        end
        d = ua.e - ub.e;
        if (d > 0)
        begin
            ua.m = ua.m << d;
            ua.e = ub.e;
        end
        else if (d < 0)
        begin
            ub.m = ub.m << (-d);
            ub.e = ua.e;
        end
        if (ua.s == ub.s)
        begin
            sum = ua.m + ub.m;
            s   = ua.s;
        end
        else if (ua.m >= ub.m)
        begin
            sum = ua.m - ub.m;
            s   = (sum == 64'd0) ? 1'b0 : ua.s;
        end
        else
        begin
            sum = ub.m - ua.m;
            s   = ub.s;
        end
        return fp_round_pack(s, sum, ua.e);
    endfunction

    function automatic logic fp32_ge(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | FP_SIGN_BIT);
        kb = b[31] ? ~b : (b | FP_SIGN_BIT);
        if (is_nan32(a) || is_nan32(b))
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b1;
        return ka >= kb;
    endfunction

    // one neuron time step: charge, fire, soft reset
    function automatic neuron_out_t neuron_step(input neuron_item_t it);
        neuron_out_t o;
        logic [31:0] mem;
        logic [31:0] drop;
        mem       = it.first ? FP_ZERO : membrane_copy[it.idx];
        o.charged = fp32_add(fp32_mul(mem, decay_copy), it.cur, 1'b0);
        o.spk     = fp32_ge(o.charged, thresh_copy);
        drop      = fp32_mul(o.spk ? FP_ONE : FP_ZERO, thresh_copy);
        membrane_copy[it.idx] = fp32_add(o.charged, drop, 1'b1);
        return o;
    endfunction

    // ---------------- item driver: bursts and gaps ----------------

    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        neuron_item_t it;
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            neuron_index <= '0;
            current_bits <= '0;
            first_step   <= 1'b0;
            burst_left   <= 4;
            gap_left     <= 0;
        end
        else
        begin
            // predict the beat taken at this edge
            if (item_valid && !item_stall)
            begin
                it.idx   = neuron_index;
                it.cur   = current_bits;
                it.first = first_step;
                expected_outs.push_back(neuron_step(it));
                items_sent = items_sent + 1;
            end
            // advance to the next beat, or hold the stalled one
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    item_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    item_valid   <= 1'b1;
                    neuron_index <= it.idx;
                    current_bits <= it.cur;
                    first_step   <= it.first;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ---------------- result stall pattern ----------------

    int stall_mode;
    int stall_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode   <= 0;
            stall_count  <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count % 48 == 47)
                stall_mode <= $urandom % 4;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom % 3 == 0);
                2: result_stall <= (stall_count % 8 < 5);
                default: result_stall <= ($urandom % 5 != 0);
            endcase
        end
    end

    // ---------------- result monitor ----------------

    always @(posedge clk)
    begin
        neuron_out_t exp_o;
        if (rst_n && result_valid && !result_stall)
        begin
            outs_seen = outs_seen + 1;
            if (expected_outs.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected result beat charged=%h spike=%b",
                         $time, charged_bits, spike);
            end
            else
            begin
                exp_o = expected_outs.pop_front();
                if (spike)
                    spikes_seen = spikes_seen + 1;
                if (charged_bits !== exp_o.charged)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: charged_bits expected %h actual %h",
                             $time, exp_o.charged, charged_bits);
                end
                if (spike !== exp_o.spk)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: spike expected %b actual %b", $time, exp_o.spk, spike);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DECAY)
            decay_copy = value;
        else
            thresh_copy = value;
    endtask

    // sample on the falling edge so driver updates from the last rising edge have settled
    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_outs.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic add_item(input logic [IDX_W-1:0] idx, input logic [31:0] cur,
                            input logic first);
        neuron_item_t it;
        it.idx   = idx;
        it.cur   = cur;
        it.first = first;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_current();
        logic [31:0] specials [8];
        specials = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                     32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h8000_0000};
        case ($urandom % 10)
            0, 1:    return $urandom;
            2:       return specials[$urandom % 8];
            3:       return {1'b0, 8'($urandom_range(0, 3)), 23'($urandom)};
            default: return {($urandom % 4 == 0), 8'($urandom_range(118, 128)),
                             23'($urandom)};
        endcase
    endfunction

    // mostly neuron groups run over several time steps, plus stray items
    task automatic add_random_phase(input int n);
        logic [IDX_W-1:0] group [8];
        int               gsize;
        int               steps;
        int               made;
        made = 0;
        while (made < n)
        begin
            if ($urandom % 6 == 0)
            begin
                add_item(IDX_W'($urandom), pick_current(), 1'($urandom % 2));
                made = made + 1;
            end
            else
            begin
                gsize = $urandom_range(1, 8);
                steps = $urandom_range(2, 8);
                for (int g = 0; g < gsize; g++)
                    group[g] = IDX_W'($urandom);
                for (int t = 0; t < steps; t++)
                    for (int g = 0; g < gsize; g++)
                        add_item(group[g], pick_current(), t == 0);
                made = made + gsize * steps;
            end
        end
    endtask

    initial
    begin
        logic [31:0] decay_set  [6];
        logic [31:0] thresh_set [6];
        decay_set  = '{32'h3F66_6666, 32'h3F80_0000, 32'hFFFF_FFFF,
                       32'h0000_0000, 32'h7F80_0000, 32'h3F73_3333};
        thresh_set = '{32'h3F80_0000, 32'h3F00_0000, 32'hFFFF_FFFF,
                       32'h7F80_0000, 32'h0000_0000, 32'h4000_0000};
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        items_sent   = 0;
        outs_seen    = 0;
        spikes_seen  = 0;
        decay_copy   = DECAY_RESET;
        thresh_copy  = THRESH_RESET;
        for (int i = 0; i < NEURONS; i++)
            membrane_copy[i] = FP_ZERO;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, NaN/inf/subnormal currents, equal-to-threshold
        add_item(10'd0, 32'h0000_0000, 1'b1);
        add_item(10'd1023, 32'hFFFF_FFFF, 1'b1);
        add_item(10'd1, 32'h3F80_0000, 1'b1);
        add_item(10'd2, 32'h7F80_0000, 1'b1);
        add_item(10'd3, 32'hFF80_0000, 1'b0);
        add_item(10'd4, 32'h7F80_0001, 1'b1);
        add_item(10'd5, 32'h0000_0001, 1'b0);
        add_item(10'd6, 32'h807F_FFFF, 1'b1);
        add_item(10'd7, 32'h7F7F_FFFF, 1'b0);
        add_item(10'd8, 32'h8000_0000, 1'b1);
        add_item(10'd1, 32'h3F00_0000, 1'b0);
        add_item(10'd2, 32'h3F80_0000, 1'b0);
        add_item(10'd1023, 32'h4000_0000, 1'b0);
        add_item(10'd1023, 32'h3F80_0000, 1'b0);
        add_random_phase(50);
        wait_idle();

        // sweep register settings, with leftover membrane state carried across
        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(REG_DECAY, decay_set[ph]);
            apb_write(REG_THRESH, thresh_set[ph]);
            if (ph == 0)
            begin
                add_item(10'd1, 32'h3F80_0000, 1'b0);
                add_item(10'd1, 32'h3F80_0000, 1'b0);
                add_item(10'd1, 32'h3F80_0000, 1'b0);
            end
            add_random_phase(52);
            wait_idle();
        end

        $display("covered %0d items, %0d results, %0d spikes over 7 register settings",
                 items_sent, outs_seen, spikes_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial
    begin
        #600000;
        $display("timeout: %0d results still expected", expected_outs.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/lifn_pkg.sv
sv/lif_neuron_soft_reset_step_unit.sv
tb/sv/tb_top.sv
